// ----- rtl/hop_pkg.sv -----
// Package for the Hopfield store and recall block: transaction payload types,
// operation codes and status codes. No dependencies.
`default_nettype none
package hop_pkg;

	localparam int PAT_W  = 64;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int NCFG_W = 7;

	// Operation codes carried in the func field.
	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR  = 2'd0,
		FN_STORE  = 2'd1,
		FN_RECALL = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	// Status codes reported with every result.
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PAT_W-1:0]  pattern;
	} item_t;

	typedef struct packed {
		logic [PAT_W-1:0]  recalled;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/hopfield_hebbian_store_recall.sv -----
// Top level of the Hopfield associative memory with Hebbian store and one
// asynchronous recall sweep. Depends on hop_pkg.
//
// Channel  Direction  Signals                          Payload
// in       input      in_valid / in_ready / in_data    hop_pkg::item_t
// out      output     out_valid / out_ready / out_data hop_pkg::result_t
// cfg      input      cfg_valid / cfg_ready / cfg_data neuron_count, 7 bits
//
// Weights live in one row-wide memory, one row per neuron, with registered read data.
// A store sweeps all MAX_NEURONS rows, read then write back.
// A recall handles each active neuron in turn (group sums, then the total and the
// neuron update); clear, refused recall and no-op go straight to the result.
// Reset needs no clearing pass; the first store rewrites every row.
// A new transaction is taken in the idle state; a finished result waits in the
// output register while the next transaction is taken, and a second finished
// result stalls until the output register is free.
`default_nettype none
module hopfield_hebbian_store_recall #(
	parameter int MAX_NEURONS = 64,
	parameter int WEIGHT_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire hop_pkg::item_t              in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output hop_pkg::result_t                 out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hop_pkg::NCFG_W-1:0]  cfg_data
);
	import hop_pkg::*;

	localparam int AW   = $clog2(MAX_NEURONS);
	localparam int NW   = $clog2(MAX_NEURONS + 1);
	localparam int RW   = MAX_NEURONS * WEIGHT_BITS;
	localparam int SUMW = WEIGHT_BITS + $clog2(MAX_NEURONS) + 1;
	localparam int NG   = (MAX_NEURONS + 7) / 8;

	localparam logic signed [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		IDLE,
		STORE,
		R_GRP,
		R_ACC,
		FIN
	} state_t;

	state_t                 state_q;
	logic                   wv_q;
	logic [NCFG_W-1:0]      ncfg_q;
	logic [NW-1:0]          n_q;
	logic [PAT_W-1:0]       pat_q;
	logic                   first_q;
	logic                   sat_q;
	logic [AW:0]            ptr_q;
	logic [AW:0]            idx_q;
	logic                   vld_s1;
	logic [AW-1:0]          addr_s1;
	logic [MAX_NEURONS-1:0] s_q;
	logic [PAT_W-1:0]       rec_q;
	logic [STAT_W-1:0]      stat_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [RW-1:0]          mem [MAX_NEURONS];
	logic [RW-1:0]          rd_q;

	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [RW-1:0]          wr_row;
	logic                   row_sat;
	logic [MAX_NEURONS-1:0] lane_en;
	logic [NW-1:0]          n_act;
	logic signed [SUMW-1:0] grp_sum [NG];
	logic signed [SUMW-1:0] grp_s1  [NG];
	logic signed [SUMW-1:0] total;
	logic                   accept;
	logic                   last_neuron;
	logic                   out_free;

	assign in_ready  = (state_q == IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Active neuron count from the register, clamped to one and MAX_NEURONS.
	always_comb begin
		if (ncfg_q == '0) begin
			n_act = NW'(1);
		end else if (ncfg_q > NCFG_W'(MAX_NEURONS)) begin
			n_act = NW'(MAX_NEURONS);
		end else begin
			n_act = NW'(ncfg_q);
		end
	end

	// Lanes below the latched neuron count take part.
	always_comb begin
		for (int j = 0; j < MAX_NEURONS; j++) begin
			lane_en[j] = (NW'(j) < n_q);
		end
	end

	assign last_neuron = ((idx_q + (AW+1)'(1)) == (AW+1)'(n_q));

	// Memory read requests: first recall row, the store sweep, the next recall row.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			IDLE: begin
				if (accept && in_data.func == FN_RECALL && wv_q) begin
					mem_re = 1'b1;
				end
			end
			STORE: begin
				if (ptr_q < (AW+1)'(MAX_NEURONS)) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
				end
			end
			R_ACC: begin
				if (!last_neuron) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0] + AW'(1);
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Hebbian update of one row: add +1 or -1 with clamping inside the active
	// square; the first store after reset or clear starts from zero everywhere.
	always_comb begin
		logic signed [WEIGHT_BITS-1:0] old_w;
		logic signed [WEIGHT_BITS-1:0] new_w;
		logic                          row_in;
		logic                          plus;
		row_sat = 1'b0;
		wr_row  = '0;
		row_in  = (NW'(addr_s1) < n_q);
		for (int j = 0; j < MAX_NEURONS; j++) begin
			old_w = first_q ? '0 : $signed(rd_q[j*WEIGHT_BITS +: WEIGHT_BITS]);
			new_w = old_w;
			plus  = (pat_q[addr_s1] == pat_q[j]);
			if (row_in && lane_en[j]) begin
				if (plus) begin
					if (old_w == WMAX) begin
						row_sat = 1'b1;
					end else begin
						new_w = old_w + WEIGHT_BITS'(1);
					end
				end else begin
					if (old_w == WMIN) begin
						row_sat = 1'b1;
					end else begin
						new_w = old_w - WEIGHT_BITS'(1);
					end
				end
			end
			wr_row[j*WEIGHT_BITS +: WEIGHT_BITS] = new_w;
		end
	end

	// First level of the field sum: signed terms in groups of eight lanes.
	always_comb begin
		logic signed [SUMW-1:0] w_ext;
		for (int g = 0; g < NG; g++) begin
			grp_sum[g] = '0;
			for (int k = 0; k < 8; k++) begin
				if (g*8 + k < MAX_NEURONS) begin
					w_ext = SUMW'($signed(rd_q[(g*8+k)*WEIGHT_BITS +: WEIGHT_BITS]));
					if (lane_en[g*8+k]) begin
						grp_sum[g] = s_q[g*8+k] ? grp_sum[g] + w_ext : grp_sum[g] - w_ext;
					end
				end
			end
		end
	end

	// Second level of the field sum over the registered group sums.
	always_comb begin
		total = '0;
		for (int g = 0; g < NG; g++) begin
			total = total + grp_s1[g];
		end
	end

	// Weight memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
		if (vld_s1) begin
			mem[addr_s1] <= wr_row;
		end
	end

	// Registered group sums.
	always_ff @(posedge clk) begin
		if (state_q == R_GRP) begin
			for (int g = 0; g < NG; g++) begin
				grp_s1[g] <= grp_sum[g];
			end
		end
	end

	// Control state machine and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			wv_q        <= 1'b0;
			ncfg_q      <= NCFG_W'(64);
			n_q         <= '0;
			pat_q       <= '0;
			first_q     <= 1'b0;
			sat_q       <= 1'b0;
			ptr_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			addr_s1     <= '0;
			s_q         <= '0;
			rec_q       <= '0;
			stat_q      <= ST_DONE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncfg_q <= cfg_data;
			end
			// The output register is loaded from FIN and emptied by the receiver.
			if (state_q == FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// A row read in the store sweep is written back in the next cycle.
			vld_s1 <= (state_q == STORE) && mem_re;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						n_q    <= n_act;
						pat_q  <= in_data.pattern;
						rec_q  <= '0;
						stat_q <= ST_DONE;
						case (in_data.func)
							FN_CLEAR: begin
								wv_q    <= 1'b0;
								state_q <= FIN;
							end
							FN_STORE: begin
								first_q <= !wv_q;
								wv_q    <= 1'b1;
								sat_q   <= 1'b0;
								ptr_q   <= '0;
								state_q <= STORE;
							end
							FN_RECALL: begin
								if (wv_q) begin
									idx_q <= '0;
									for (int j = 0; j < MAX_NEURONS; j++) begin
										s_q[j] <= in_data.pattern[j] && (NW'(j) < n_act);
									end
									state_q <= R_GRP;
								end else begin
									stat_q  <= ST_REFUSED;
									state_q <= FIN;
								end
							end
							default: begin
								state_q <= FIN;
							end
						endcase
					end
				end
				STORE: begin
					if (mem_re) begin
						addr_s1 <= ptr_q[AW-1:0];
						ptr_q   <= ptr_q + (AW+1)'(1);
					end
					if (vld_s1 && row_sat) begin
						sat_q <= 1'b1;
					end
					if (!mem_re && !vld_s1) begin
						stat_q  <= sat_q ? ST_SAT : ST_DONE;
						state_q <= FIN;
					end
				end
				R_GRP: begin
					state_q <= R_ACC;
				end
				R_ACC: begin
					s_q[idx_q[AW-1:0]] <= (total > 0);
					if (last_neuron) begin
						for (int j = 0; j < MAX_NEURONS; j++) begin
							rec_q[j] <= (j == int'(idx_q[AW-1:0])) ? (total > 0) : s_q[j];
						end
						state_q <= FIN;
					end else begin
						idx_q   <= idx_q + (AW+1)'(1);
						state_q <= R_GRP;
					end
				end
				FIN: begin
					if (out_free) begin
						out_q.recalled <= rec_q;
						out_q.status   <= stat_q;
						state_q        <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
